// ----- sv/assert_macros.svh -----
// assertion macros shared by the expander rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define TRPE_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TRPE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TRPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/trpe_pkg.sv -----
// shared types, constants and field layout for the tile row pixel expander
`timescale 1ns / 1ps

package trpe_pkg;

  localparam int PALETTE_ENTRIES_DEF = 16;
  localparam int ROW_PIXELS          = 8;
  localparam int COLOR_W             = 16;
  localparam int INDEX_W             = 8;
  localparam int LIMIT_W             = INDEX_W + 1;

  // input tdata layout
  localparam int ROW_LSB    = 0;
  localparam int ROW_W      = ROW_PIXELS * INDEX_W;
  localparam int SLOT_LSB   = ROW_LSB + ROW_W;
  localparam int SLOT_W     = 4;
  localparam int VALUE_LSB  = SLOT_LSB + SLOT_W;
  localparam int GLYPH_LSB  = VALUE_LSB + COLOR_W;
  localparam int GLYPH_W    = 8;
  localparam int CHAR_LSB   = GLYPH_LSB + GLYPH_W;
  localparam int CHAR_W     = 8;
  localparam int IN_FIELD_W = CHAR_LSB + CHAR_W;
  localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;

  // input tuser layout
  localparam int OP_W      = 2;
  localparam int TSTART_BIT = OP_W;
  localparam int IN_USER_W = OP_W + 1;

  localparam int OUT_DATA_W = ROW_PIXELS * COLOR_W;

  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0]  CHAR_FIRST  = 8'd32;
  localparam logic [CHAR_W-1:0]  CHAR_LAST   = 8'd126;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 16'hFFFF;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 16'h0000;

  typedef enum logic [OP_W-1:0] {
    OP_PALETTE = 2'd0,
    OP_SPRITE  = 2'd1,
    OP_TEXT    = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_FG = 1'd0,
    CFG_TEXT_BG = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                sprite;
    logic                char_ok;
    logic [GLYPH_W-1:0]  glyph;
  } s1_t;

endpackage

// ----- sv/trpe_pal_ram.sv -----
// one palette copy: single write port, single registered read port
`timescale 1ns / 1ps

module trpe_pal_ram #(
  parameter int ENTRIES = trpe_pkg::PALETTE_ENTRIES_DEF,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [trpe_pkg::COLOR_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [trpe_pkg::COLOR_W-1:0] rd_data
);
  import trpe_pkg::*;

  logic [COLOR_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  logic [COLOR_W-1:0] rd_data_r;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/tile_row_pixel_expander_top.sv -----
// tile row pixel expander: palette writes, sprite rows and text rows to rgb565
//
//   channel  dir  tdata                                          tuser
//   in_      in   row_indices, palette_slot, palette_value,      operation, tile_start
//                 glyph_bits, char_code
//   out_     out  color0 .. color7                               drawn
//   cfg_     in   write: cfg_we, cfg_index, cfg_wdata            -
//
// one request accepted per cycle unless in_tready is low; a row result passes through stage one
// and the output register; the carried index is resolved at acceptance, palette reads land in stage one,
// color selection feeds the output register
// reset is synchronous and clears the palette valid bits
// with out_tready low the output holds, stage one fills, then in_tready drops
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tile_row_pixel_expander_top #(
  parameter int PALETTE_ENTRIES = trpe_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // row_indices, palette_slot, palette_value, glyph_bits, char_code, zero pad
  input  logic [trpe_pkg::IN_DATA_W-1:0]   in_tdata,
  // operation, tile_start
  input  logic [trpe_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // color0, color1, color2, color3, color4, color5, color6, color7
  output logic [trpe_pkg::OUT_DATA_W-1:0]  out_tdata,
  // drawn
  output logic                             out_tuser,
  input  logic                             cfg_we,
  input  logic [trpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trpe_pkg::COLOR_W-1:0]     cfg_wdata
);
  import trpe_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [LIMIT_W-1:0] IDX_LIM = LIMIT_W'(PALETTE_ENTRIES);

  op_t                in_op;
  logic               in_tile_start;
  logic [ROW_W-1:0]   in_row;
  logic [SLOT_W-1:0]  in_slot;
  logic [COLOR_W-1:0] in_value;
  logic [GLYPH_W-1:0] in_glyph;
  logic [CHAR_W-1:0]  in_char;
  logic               in_acc;
  logic               s1_adv;

  logic [COLOR_W-1:0] cfg_fg_r;
  logic [COLOR_W-1:0] cfg_bg_r;

  logic [AW-1:0]      carry_r;
  logic [AW-1:0]      carry_nxt;
  logic [AW-1:0]      rd_addr [ROW_PIXELS];
  logic [COLOR_W-1:0] rd_data [ROW_PIXELS];
  logic               pal_wr_en;
  logic [AW-1:0]      pal_wr_addr;
  logic               sprite_rd;

  logic               s1_valid_r;
  s1_t                s1_r;
  s1_t                s1_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic                  out_drawn_r;
  logic                  out_drawn_nxt;

  assign in_op         = op_t'(in_tuser[OP_W-1:0]);
  assign in_tile_start = in_tuser[TSTART_BIT];
  assign in_row        = in_tdata[ROW_LSB +: ROW_W];
  assign in_slot       = in_tdata[SLOT_LSB +: SLOT_W];
  assign in_value      = in_tdata[VALUE_LSB +: COLOR_W];
  assign in_glyph      = in_tdata[GLYPH_LSB +: GLYPH_W];
  assign in_char       = in_tdata[CHAR_LSB +: CHAR_W];

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fg_r <= '0;
      cfg_bg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TEXT_FG: cfg_fg_r <= cfg_wdata;
        CFG_TEXT_BG: cfg_bg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // carried index chain across the eight columns
  always_comb begin
    logic [AW-1:0]      c;
    logic [AW-1:0]      eff;
    logic [INDEX_W-1:0] idx;
    c   = in_tile_start ? '0 : carry_r;
    eff = '0;
    idx = '0;
    for (int i = 0; i < ROW_PIXELS; i++) begin
      idx = in_row[i*INDEX_W +: INDEX_W];
      if ({1'b0, idx} >= IDX_LIM) begin
        eff = c;
      end else begin
        eff = AW'(idx);
        if (idx != '0) begin
          c = eff;
        end
      end
      rd_addr[i] = (eff == '0) ? AW'(1) : eff;
    end
    carry_nxt = c;
  end

  assign sprite_rd   = in_acc && (in_op == OP_SPRITE);
  assign pal_wr_en   = in_acc && (in_op == OP_PALETTE) && ({5'b0, in_slot} < IDX_LIM);
  assign pal_wr_addr = AW'({5'b0, in_slot});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
    end else if (sprite_rd) begin
      carry_r <= carry_nxt;
    end
  end

  // one palette copy per pixel column
  for (genvar g = 0; g < ROW_PIXELS; g++) begin : g_pal
    trpe_pal_ram #(
      .ENTRIES (PALETTE_ENTRIES)
    ) u_pal (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (pal_wr_en),
      .wr_addr (pal_wr_addr),
      .wr_data (in_value),
      .rd_en   (sprite_rd),
      .rd_addr (rd_addr[g]),
      .rd_data (rd_data[g])
    );
  end

  // stage one
  always_comb begin
    s1_nxt.sprite  = (in_op == OP_SPRITE);
    s1_nxt.char_ok = (in_char >= CHAR_FIRST) && (in_char <= CHAR_LAST);
    s1_nxt.glyph   = in_glyph;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_acc && ((in_op == OP_SPRITE) || (in_op == OP_TEXT));
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  // color selection
  always_comb begin
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    fg = cfg_fg_r;
    bg = cfg_bg_r;
    if ((cfg_fg_r == '0) && (cfg_bg_r == '0)) begin
      fg = COLOR_WHITE;
      bg = COLOR_BLACK;
    end
    out_data_nxt  = '0;
    out_drawn_nxt = 1'b1;
    if (s1_r.sprite) begin
      for (int i = 0; i < ROW_PIXELS; i++) begin
        out_data_nxt[i*COLOR_W +: COLOR_W] = rd_data[i];
      end
    end else if (s1_r.char_ok) begin
      for (int i = 0; i < ROW_PIXELS; i++) begin
        out_data_nxt[i*COLOR_W +: COLOR_W] = s1_r.glyph[i] ? fg : bg;
      end
    end else begin
      out_drawn_nxt = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r  <= out_data_nxt;
      out_drawn_r <= out_drawn_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_drawn_r;

  `TRPE_ASSERT_IMPL(a_skip_blank, out_tvalid && !out_tuser, out_tdata == '0, "skipped row not blank")
  `TRPE_ASSERT_NEXT(a_row_enters, in_acc && (in_op == OP_SPRITE || in_op == OP_TEXT), s1_valid_r, "accepted row lost")
  `TRPE_ASSERT_NEXT(a_pal_silent, in_acc && in_op == OP_PALETTE && !s1_valid_r, !s1_valid_r, "palette write made a result")
  `TRPE_ASSERT_ALWAYS(a_carry_range, {1'b0, carry_r} < IDX_LIM, "carried index out of range")

endmodule

// ----- tb/sv/tile_row_pixel_expander_top_tb.sv -----
// testbench for the tile row pixel expander: directed and random rows against a shadow model
`timescale 1ns / 1ps

module tile_row_pixel_expander_top_tb;
  import trpe_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [OUT_DATA_W-1:0] colors;
    logic                  drawn;
  } row_colors_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COLOR_W-1:0]    cfg_wdata = '0;

  logic [COLOR_W-1:0]    palette_shadow [PALETTE_ENTRIES_DEF];
  logic [3:0]            carry_shadow;
  logic [COLOR_W-1:0]    fg_shadow;
  logic [COLOR_W-1:0]    bg_shadow;
  row_colors_t           row_colors_q [$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_len = 0;
  int fail_count = 0;
  int rows_checked = 0;
  int sprite_rows = 0;
  int text_rows = 0;
  int skipped_rows = 0;
  int palette_writes = 0;
  int color_settings = 0;

  tile_row_pixel_expander_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  // receiver: long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_tready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    row_colors_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (row_colors_q.size() == 0) begin
        $display("%0t: unexpected row result expected none actual colors=%h drawn=%b",
                 $time, out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = row_colors_q.pop_front();
        rows_checked++;
        for (int c = 0; c < ROW_PIXELS; c++) begin
          if (out_tdata[c*COLOR_W +: COLOR_W] !== want.colors[c*COLOR_W +: COLOR_W]) begin
            $display("%0t: color%0d mismatch expected %h actual %h", $time, c,
                     want.colors[c*COLOR_W +: COLOR_W], out_tdata[c*COLOR_W +: COLOR_W]);
            fail_count++;
          end
        end
        if (out_tuser !== want.drawn) begin
          $display("%0t: drawn mismatch expected %b actual %b", $time, want.drawn, out_tuser);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_fields(logic [ROW_W-1:0] row,
                                                       logic [SLOT_W-1:0] slot,
                                                       logic [COLOR_W-1:0] value,
                                                       logic [GLYPH_W-1:0] glyph,
                                                       logic [CHAR_W-1:0] ch);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[ROW_LSB +: ROW_W] = row;
    d[SLOT_LSB +: SLOT_W] = slot;
    d[VALUE_LSB +: COLOR_W] = value;
    d[GLYPH_LSB +: GLYPH_W] = glyph;
    d[CHAR_LSB +: CHAR_W] = ch;
    return d;
  endfunction

  task automatic predict_row(input logic [IN_USER_W-1:0] user, input logic [IN_DATA_W-1:0] data);
    row_colors_t r;
    logic [OP_W-1:0] op;
    logic [INDEX_W-1:0] idx;
    logic [3:0] eff;
    logic [GLYPH_W-1:0] glyph;
    logic [CHAR_W-1:0] ch;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    op = user[OP_W-1:0];
    r = '0;
    case (op)
      OP_PALETTE: begin
        palette_shadow[data[SLOT_LSB +: SLOT_W]] = data[VALUE_LSB +: COLOR_W];
        palette_writes++;
      end
      OP_SPRITE: begin
        if (user[TSTART_BIT]) carry_shadow = '0;
        for (int c = 0; c < ROW_PIXELS; c++) begin
          idx = data[ROW_LSB + c*INDEX_W +: INDEX_W];
          if (idx >= PALETTE_ENTRIES_DEF) begin
            eff = carry_shadow;
          end else begin
            eff = idx[3:0];
            if (idx != 0) carry_shadow = idx[3:0];
          end
          if (eff == 0) eff = 4'd1;
          r.colors[c*COLOR_W +: COLOR_W] = palette_shadow[eff];
        end
        r.drawn = 1'b1;
        row_colors_q.push_back(r);
        sprite_rows++;
      end
      OP_TEXT: begin
        glyph = data[GLYPH_LSB +: GLYPH_W];
        ch = data[CHAR_LSB +: CHAR_W];
        fg = fg_shadow;
        bg = bg_shadow;
        if (fg == 0 && bg == 0) begin
          fg = COLOR_WHITE;
          bg = COLOR_BLACK;
        end
        if (ch >= CHAR_FIRST && ch <= CHAR_LAST) begin
          for (int c = 0; c < ROW_PIXELS; c++)
            r.colors[c*COLOR_W +: COLOR_W] = glyph[c] ? fg : bg;
          r.drawn = 1'b1;
        end else begin
          skipped_rows++;
        end
        row_colors_q.push_back(r);
        text_rows++;
      end
      default: ;
    endcase
  endtask

  task automatic push_request(input logic [IN_USER_W-1:0] user, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= user;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_row(user, data);
  endtask

  task automatic send_palette(input logic [SLOT_W-1:0] slot, input logic [COLOR_W-1:0] value);
    push_request({1'b0, OP_PALETTE},
                 pack_fields({$urandom, $urandom}, slot, value,
                             GLYPH_W'($urandom), CHAR_W'($urandom)));
  endtask

  task automatic send_sprite(input logic tstart, input logic [ROW_W-1:0] row);
    push_request({tstart, OP_SPRITE},
                 pack_fields(row, SLOT_W'($urandom), COLOR_W'($urandom),
                             GLYPH_W'($urandom), CHAR_W'($urandom)));
  endtask

  task automatic send_text(input logic [GLYPH_W-1:0] glyph, input logic [CHAR_W-1:0] ch);
    push_request({1'b1, OP_TEXT},
                 pack_fields({$urandom, $urandom}, SLOT_W'($urandom), COLOR_W'($urandom),
                             glyph, ch));
  endtask

  task automatic drain_rows();
    in_tvalid <= 1'b0;
    while (row_colors_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_text_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    drain_rows();
    cfg_we <= 1'b1;
    cfg_index <= CFG_TEXT_FG;
    cfg_wdata <= fg;
    @(posedge clk);
    fg_shadow = fg;
    cfg_index <= CFG_TEXT_BG;
    cfg_wdata <= bg;
    @(posedge clk);
    bg_shadow = bg;
    cfg_we <= 1'b0;
    @(posedge clk);
    color_settings++;
  endtask

  function automatic logic [ROW_W-1:0] rand_sprite_row();
    logic [ROW_W-1:0] row;
    int k;
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    for (int c = 0; c < ROW_PIXELS; c++) begin
      k = $urandom_range(9);
      if (k < 2) row[c*INDEX_W +: INDEX_W] = '0;
      else if (k < 5) row[c*INDEX_W +: INDEX_W] = INDEX_W'($urandom_range(15));
      else row[c*INDEX_W +: INDEX_W] = INDEX_W'($urandom_range(255, 16));
    end
    return row;
  endfunction

  task automatic test_directed_sprite();
    send_palette(4'd0, 16'h1234);
    send_palette(4'd1, 16'hFFFF);
    send_palette(4'd15, 16'h8001);
    send_palette(4'd7, 16'h0000);
    send_palette(4'd14, 16'h5AA5);
    // zero indices and out-of-range with no carry both hit entry one
    send_sprite(1'b1, 64'h0000_0000_0000_0000);
    send_sprite(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sprite(1'b0, 64'h0E80_01FF_0700_100F);
    // carry survives rows and a palette write
    send_sprite(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_palette(4'd14, 16'hC3C3);
    send_sprite(1'b0, 64'h2020_2020_2020_2020);
    push_request({1'b1, OP_RESERVED},
                 pack_fields({$urandom, $urandom}, 4'd1, 16'hDEAD, 8'hFF, 8'd65));
    send_sprite(1'b1, 64'h4040_4040_4040_4040);
  endtask

  task automatic test_directed_text();
    // reset colors are both zero so white on black applies
    send_text(8'hA5, 8'd32);
    send_text(8'hFF, 8'd126);
    send_text(8'h00, 8'd31);
    send_text(8'hFF, 8'd127);
    send_text(8'h5A, 8'd0);
    send_text(8'h00, 8'd255);
    set_text_colors(16'hF800, 16'h001F);
    send_text(8'h01, 8'd65);
    send_text(8'h80, 8'd90);
    set_text_colors(16'h0000, 16'h07E0);
    send_text(8'h3C, 8'd100);
    send_text(8'hC3, 8'd200);
  endtask

  task automatic test_random_phase(input int src_pct, input int snk_pct,
                                   input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                                   input int count);
    int sent;
    int k;
    set_text_colors(fg, bg);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    sent = 0;
    while (sent < count) begin
      k = $urandom_range(99);
      if (k < 20) begin
        send_palette(SLOT_W'($urandom), COLOR_W'($urandom));
        sent++;
      end else if (k < 65) begin
        send_sprite($urandom_range(3) == 0, rand_sprite_row());
        sent++;
      end else if (k < 95) begin
        send_text(GLYPH_W'($urandom),
                  ($urandom_range(9) < 7) ? CHAR_W'($urandom_range(126, 32))
                                          : CHAR_W'($urandom_range(255)));
        sent++;
      end else begin
        push_request({1'($urandom), OP_RESERVED},
                     pack_fields({$urandom, $urandom}, SLOT_W'($urandom), COLOR_W'($urandom),
                                 GLYPH_W'($urandom), CHAR_W'($urandom)));
      end
    end
  endtask

  task automatic test_backpressure();
    set_text_colors(COLOR_W'($urandom), COLOR_W'($urandom));
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_len = 300;
    for (int i = 0; i < 100; i++) begin
      if (i % 3 == 0) send_text(GLYPH_W'($urandom), CHAR_W'($urandom_range(126, 32)));
      else send_sprite($urandom_range(3) == 0, rand_sprite_row());
    end
  endtask

  initial begin
    for (int i = 0; i < PALETTE_ENTRIES_DEF; i++) palette_shadow[i] = '0;
    carry_shadow = '0;
    fg_shadow = '0;
    bg_shadow = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_sprite();
    test_directed_text();
    test_random_phase(0, 0, 16'h0000, 16'h0000, 360);
    test_random_phase(60, 0, 16'hFFFF, 16'hFFFF, 360);
    test_random_phase(0, 60, 16'h0000, 16'hFFFF, 360);
    test_random_phase(14, 14, 16'hFFFF, 16'h0000, 360);
    test_backpressure();
    test_random_phase(14, 14, COLOR_W'($urandom), COLOR_W'($urandom), 100);
    drain_rows();
    $display("covered %0d sprite rows, %0d text rows (%0d skipped), %0d palette writes",
             sprite_rows, text_rows, skipped_rows, palette_writes);
    $display("%0d rows checked over %0d text color settings, %0d mismatches",
             rows_checked, color_settings, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- tile_row_pixel_expander_top.f -----
+incdir+sv
sv/trpe_pkg.sv
sv/trpe_pal_ram.sv
sv/tile_row_pixel_expander_top.sv
tb/sv/tile_row_pixel_expander_top_tb.sv
